[hdl/gem_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gem_pkg
// Shared types and constants of the RGB gradient edge map block.
// ---------------------------------------------------------------------------
package gem_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_W          = 11;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;
    localparam int MIN_SIZE       = 3;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // Channel 0 is red, 1 is green, 2 is blue.
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;

    // Neighborhood of one center, handed from the line buffer to the datapath.
    typedef struct packed {
        logic emit;
        logic last;
        pix_t left;
        pix_t right;
        pix_t up;
        pix_t down;
    } tap_t;

endpackage
`default_nettype wire

[hdl/gem_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gem_if
// Handshake channels of the edge map block: pixel input, result output and
// configuration write.
// ---------------------------------------------------------------------------
interface gem_pix_if;
    logic                       valid;
    logic                       ready;
    logic [gem_pkg::CHAN_W-1:0] red_in;
    logic [gem_pkg::CHAN_W-1:0] green_in;
    logic [gem_pkg::CHAN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface gem_res_if #(
    parameter int COL_W = 10,
    parameter int ROW_W = 10
);
    logic                       valid;
    logic                       ready;
    logic [gem_pkg::CHAN_W-1:0] red_out;
    logic [gem_pkg::CHAN_W-1:0] green_out;
    logic [gem_pkg::CHAN_W-1:0] blue_out;
    logic [COL_W-1:0]           center_col;
    logic [ROW_W-1:0]           center_row;
    logic                       frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output center_col, output center_row, output frame_last,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input center_col, input center_row, input frame_last,
                    output ready);
endinterface

interface gem_cfg_if;
    logic                      valid;
    logic                      ready;
    gem_pkg::cfg_index_t       index;
    logic [gem_pkg::CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/gem_line_buf.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gem_line_buf
// Two row stores with a registered read port each, the raster position
// counters and the small register window that feeds each center.
// ---------------------------------------------------------------------------
module gem_line_buf #(
    parameter int MAX_WIDTH  = gem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gem_pkg::MAX_HEIGHT_DEF,
    parameter int COL_W      = $clog2(MAX_WIDTH),
    parameter int ROW_W      = $clog2(MAX_HEIGHT),
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire gem_pkg::pix_t pixel,
    input  wire logic [WW-1:0] size_w,
    input  wire logic [HW-1:0] size_h,
    output gem_pkg::tap_t      tap,
    output logic [COL_W-1:0]   col,
    output logic [ROW_W-1:0]   row
);

    gem_pkg::pix_t mid_mem [MAX_WIDTH];
    gem_pkg::pix_t up_mem  [MAX_WIDTH];

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    gem_pkg::pix_t    mid_rd_reg;
    gem_pkg::pix_t    up_rd_reg;
    gem_pkg::pix_t    mid_cur_reg, mid_cur_next;
    gem_pkg::pix_t    left_reg;
    gem_pkg::pix_t    mid0_reg;

    logic [31:0]      c32, r32, w32, h32;
    logic             col_wrap;
    logic [COL_W-1:0] rd_col;
    logic [COL_W-1:0] mid_addr;

    assign c32 = 32'(col_reg);
    assign r32 = 32'(row_reg);
    assign w32 = 32'(size_w);
    assign h32 = 32'(size_h);

    assign col_wrap = (c32 + 32'd1) >= w32;

    always_comb
    begin
        if (col_wrap)
        begin
            col_next = '0;
            row_next = ((r32 + 32'd1) >= h32) ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    // The stores are read one column ahead: the upper store at the next
    // column and the middle store one past it. The middle value of the next
    // column is then already in the window, except at a row start, where it
    // comes from the copy of column zero.
    assign rd_col   = accept ? col_next : col_reg;
    assign mid_addr = (rd_col == COL_W'(MAX_WIDTH - 1)) ? '0 : rd_col + 1'b1;

    assign mid_cur_next = col_wrap ? mid0_reg : mid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_mem[col_reg] <= pixel;
            up_mem[col_reg]  <= mid_cur_reg;
        end
        mid_rd_reg <= mid_mem[mid_addr];
        up_rd_reg  <= up_mem[rd_col];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_cur_reg <= mid_cur_next;
            left_reg    <= mid_cur_reg;
            if (col_reg == '0)
            begin
                mid0_reg <= pixel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign tap.emit  = (r32 >= 32'd2) && (r32 < h32) && (c32 >= 32'd1)
                       && ((c32 + 32'd2) <= w32);
    assign tap.last  = ((c32 + 32'd2) == w32) && ((r32 + 32'd1) == h32);
    assign tap.left  = left_reg;
    assign tap.right = mid_rd_reg;
    assign tap.up    = up_rd_reg;
    assign tap.down  = pixel;

    assign col = col_reg;
    assign row = row_reg - 1'b1;

endmodule
`default_nettype wire

[hdl/gem_grad_pipe.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gem_grad_pipe
// Gradient datapath: halved central differences, sum of squares and an
// eight-step integer square root pipeline whose last step holds the result.
// ---------------------------------------------------------------------------
module gem_grad_pipe #(
    parameter int COL_W = 10,
    parameter int ROW_W = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    output logic                            in_ready,
    input  wire gem_pkg::tap_t              tap,
    input  wire logic [COL_W-1:0]           col,
    input  wire logic [ROW_W-1:0]           row,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [gem_pkg::CHAN_W-1:0]      red_out,
    output logic [gem_pkg::CHAN_W-1:0]      green_out,
    output logic [gem_pkg::CHAN_W-1:0]      blue_out,
    output logic [COL_W-1:0]                center_col,
    output logic [ROW_W-1:0]                center_row,
    output logic                            frame_last
);

    localparam int NCH   = gem_pkg::NUM_CHAN;
    localparam int STEPS = gem_pkg::CHAN_W;
    localparam int NS    = STEPS + 2;
    localparam int SQ_W  = 2 * gem_pkg::CHAN_W;

    function automatic logic signed [gem_pkg::CHAN_W-1:0] half_diff(
        input logic [gem_pkg::CHAN_W-1:0] a,
        input logic [gem_pkg::CHAN_W-1:0] b
    );
        logic signed [gem_pkg::CHAN_W:0] d;
        logic signed [gem_pkg::CHAN_W:0] h;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        // Halve toward zero: negative values are biased up by one first.
        h = d[gem_pkg::CHAN_W] ? ((d + $signed((gem_pkg::CHAN_W+1)'(1))) >>> 1)
                               : (d >>> 1);
        return h[gem_pkg::CHAN_W-1:0];
    endfunction

    logic                               v_reg   [NS];
    logic                               rdy     [NS+1];
    logic [COL_W-1:0]                   col_reg [NS];
    logic [ROW_W-1:0]                   row_reg [NS];
    logic                               last_reg[NS];

    logic signed [gem_pkg::CHAN_W-1:0]  dx_reg  [NCH];
    logic signed [gem_pkg::CHAN_W-1:0]  dy_reg  [NCH];
    logic [SQ_W-1:0]                    rem_reg [STEPS+1][NCH];
    logic [SQ_W-1:0]                    root_reg[STEPS+1][NCH];
    logic [SQ_W-1:0]                    rem_nx  [STEPS][NCH];
    logic [SQ_W-1:0]                    root_nx [STEPS][NCH];
    logic [SQ_W-1:0]                    sum_sq  [NCH];

    // A stage takes new data when it is empty or its contents move on.
    always_comb
    begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        logic signed [SQ_W-1:0] sqx;
        logic signed [SQ_W-1:0] sqy;
        for (int ch = 0; ch < NCH; ch++)
        begin
            sqx = dx_reg[ch] * dx_reg[ch];
            sqy = dy_reg[ch] * dy_reg[ch];
            sum_sq[ch] = SQ_W'(sqx + sqy);
        end
    end

    // One result bit per stage, from the top bit of the root down.
    always_comb
    begin
        logic [SQ_W-1:0] bitv;
        logic [SQ_W:0]   trial;
        for (int k = 0; k < STEPS; k++)
        begin
            bitv = SQ_W'(1) << (2 * (STEPS - 1 - k));
            for (int ch = 0; ch < NCH; ch++)
            begin
                trial = {1'b0, root_reg[k][ch]} + {1'b0, bitv};
                if ({1'b0, rem_reg[k][ch]} >= trial)
                begin
                    rem_nx[k][ch]  = rem_reg[k][ch] - trial[SQ_W-1:0];
                    root_nx[k][ch] = (root_reg[k][ch] >> 1) + bitv;
                end
                else
                begin
                    rem_nx[k][ch]  = rem_reg[k][ch];
                    root_nx[k][ch] = root_reg[k][ch] >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                dx_reg[ch] <= half_diff(tap.right[ch], tap.left[ch]);
                dy_reg[ch] <= half_diff(tap.down[ch], tap.up[ch]);
            end
            col_reg[0]  <= col;
            row_reg[0]  <= row;
            last_reg[0] <= tap.last;
        end
        if (rdy[1])
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                rem_reg[0][ch]  <= sum_sq[ch];
                root_reg[0][ch] <= '0;
            end
        end
        for (int k = 0; k < STEPS; k++)
        begin
            if (rdy[k+2])
            begin
                for (int ch = 0; ch < NCH; ch++)
                begin
                    rem_reg[k+1][ch]  <= rem_nx[k][ch];
                    root_reg[k+1][ch] <= root_nx[k][ch];
                end
            end
        end
        for (int i = 1; i < NS; i++)
        begin
            if (rdy[i])
            begin
                col_reg[i]  <= col_reg[i-1];
                row_reg[i]  <= row_reg[i-1];
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= load;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // The root never exceeds 179, so 255 minus it is the bitwise inverse.
    assign out_valid  = v_reg[NS-1];
    assign red_out    = ~root_reg[STEPS][0][gem_pkg::CHAN_W-1:0];
    assign green_out  = ~root_reg[STEPS][1][gem_pkg::CHAN_W-1:0];
    assign blue_out   = ~root_reg[STEPS][2][gem_pkg::CHAN_W-1:0];
    assign center_col = col_reg[NS-1];
    assign center_row = row_reg[NS-1];
    assign frame_last = last_reg[NS-1];

endmodule
`default_nettype wire

[hdl/rgb_gradient_edge_map_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_gradient_edge_map_unit
// Streaming RGB edge map: gradient magnitude per channel over a 3x3 cross.
// Pipeline: a result passes the difference register, the square sum register
// and the eight root step registers, in that order, the first loaded when the
// pixel below its center is accepted. Throughput: one pixel per cycle while
// the result output is not stalled, set by the single read port per row store
// (read one column ahead) and the one-bit-per-stage root pipeline. Reset
// clears the position counters and pipeline valids and loads 640x480; the row
// stores are not cleared and hold no data until the first two rows are written.
// ---------------------------------------------------------------------------
module rgb_gradient_edge_map_unit #(
    parameter int MAX_WIDTH  = gem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gem_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gem_pix_if.sink   pix,
    gem_cfg_if.sink   cfg,
    gem_res_if.source res
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = gem_pkg::CFG_W;

    logic [CW-1:0]    width_reg;
    logic [CW-1:0]    height_reg;
    logic [WW-1:0]    size_w;
    logic [HW-1:0]    size_h;
    logic             in_ready;
    logic             accept;
    gem_pkg::pix_t    pixel;
    gem_pkg::tap_t    tap;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW'(gem_pkg::WIDTH_RESET);
            height_reg <= CW'(gem_pkg::HEIGHT_RESET);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                gem_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg.data;
                gem_pkg::REG_FRAME_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Sizes outside the supported range act as the nearest limit.
    always_comb
    begin
        if (32'(width_reg) < 32'(gem_pkg::MIN_SIZE))
            size_w = WW'(gem_pkg::MIN_SIZE);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            size_w = WW'(MAX_WIDTH);
        else
            size_w = WW'(width_reg);

        if (32'(height_reg) < 32'(gem_pkg::MIN_SIZE))
            size_h = HW'(gem_pkg::MIN_SIZE);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            size_h = HW'(MAX_HEIGHT);
        else
            size_h = HW'(height_reg);
    end

    assign pixel     = {pix.blue_in, pix.green_in, pix.red_in};
    assign pix.ready = in_ready;
    assign accept    = pix.valid && in_ready;

    gem_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W),
        .WW         (WW),
        .HW         (HW)
    ) u_line_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pixel  (pixel),
        .size_w (size_w),
        .size_h (size_h),
        .tap    (tap),
        .col    (col),
        .row    (row)
    );

    gem_grad_pipe #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_grad_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && tap.emit),
        .in_ready   (in_ready),
        .tap        (tap),
        .col        (col),
        .row        (row),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .red_out    (res.red_out),
        .green_out  (res.green_out),
        .blue_out   (res.blue_out),
        .center_col (res.center_col),
        .center_row (res.center_row),
        .frame_last (res.frame_last)
    );

endmodule
`default_nettype wire

[bench/rgb_gradient_edge_map_unit_test.sv]
// ---------------------------------------------------------------------------
// rgb_gradient_edge_map_unit_test
// Self-checking bench for the RGB edge map block. Pixels are streamed in
// raster order and a line-buffer predictor computes, for every interior
// center, the three channel results, position and frame-end flag. Each
// result item that leaves the block is checked against the oldest
// prediction. Frame sizes are changed between frames and mid-frame.
// ---------------------------------------------------------------------------
module rgb_gradient_edge_map_unit_test;
    import gem_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 4;
    localparam int PIPE_SETTLE  = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 900;
    localparam int NUM_PHASES   = 3;
    localparam int SRC_IDLE [NUM_PHASES] = '{7, 62, 0};
    localparam int SINK_IDLE[NUM_PHASES] = '{62, 7, 0};

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [9:0]        col;
        logic [9:0]        row;
        logic              last;
    } edge_result_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_FLAT,
        FILL_BINARY,
        FILL_RAMP
    } fill_mode_t;

    logic clk;
    logic rst_n;

    gem_pix_if pix_ch();
    gem_cfg_if cfg_ch();
    gem_res_if res_ch();

    rgb_gradient_edge_map_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .cfg   (cfg_ch),
        .res   (res_ch)
    );

    // Predictor state: two row stores, the left-neighbor hold and the position.
    pix_t             upper_row [MAX_WIDTH_DEF];
    pix_t             middle_row[MAX_WIDTH_DEF];
    pix_t             left_hold;
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    edge_result_t pending_edges[$];
    edge_result_t head_edge;

    int          src_idle_pct;
    int          sink_idle_pct;
    int unsigned cycle_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned results_seen = 0;
    int unsigned frames_seen = 0;
    int unsigned error_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned max_size);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > max_size)
            return max_size;
        return 32'(v);
    endfunction

    // Halved central differences truncate toward zero, as SystemVerilog int division does.
    function automatic logic [CHAN_W-1:0] channel_edge(logic [CHAN_W-1:0] lf,
                                                       logic [CHAN_W-1:0] rt,
                                                       logic [CHAN_W-1:0] up,
                                                       logic [CHAN_W-1:0] dn);
        int          dx;
        int          dy;
        int unsigned mag_sq;
        int unsigned root;
        dx = (int'(rt) - int'(lf)) / 2;
        dy = (int'(dn) - int'(up)) / 2;
        mag_sq = dx * dx + dy * dy;
        root = 0;
        for (int b = CHAN_W - 1; b >= 0; b--)
        begin
            if ((root | (1 << b)) * (root | (1 << b)) <= mag_sq)
                root = root | (1 << b);
        end
        return 8'(255 - root);
    endfunction

    function automatic pix_t random_pixel();
        return pix_t'(24'($urandom));
    endfunction

    function automatic pix_t fill_pixel(fill_mode_t mode, int x, int y, pix_t flat);
        pix_t p;
        case (mode)
            FILL_FLAT:
                p = flat;
            FILL_BINARY:
            begin
                for (int ch = 0; ch < NUM_CHAN; ch++)
                    p[ch] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
            FILL_RAMP:
            begin
                p[0] = 8'(x * 23 + y * 7);
                p[1] = 8'(255 - x * 31);
                p[2] = 8'(y * 53 + x);
            end
            default:
                p = random_pixel();
        endcase
        return p;
    endfunction

    task automatic predict_edge_map(input pix_t cur);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        pix_t         old_mid;
        edge_result_t e;
        w = clamp_size(width_reg, MAX_WIDTH_DEF);
        h = clamp_size(height_reg, MAX_HEIGHT_DEF);
        c = col_pos;
        r = row_pos;
        old_mid = middle_row[c];
        if (r >= 2 && r < h && c >= 1 && c + 2 <= w)
        begin
            e.red   = channel_edge(left_hold[0], middle_row[c + 1][0], upper_row[c][0], cur[0]);
            e.green = channel_edge(left_hold[1], middle_row[c + 1][1], upper_row[c][1], cur[1]);
            e.blue  = channel_edge(left_hold[2], middle_row[c + 1][2], upper_row[c][2], cur[2]);
            e.col   = 10'(c);
            e.row   = 10'(r - 1);
            e.last  = (c + 2 == w) && (r + 1 == h);
            pending_edges.push_back(e);
        end
        upper_row[c] = old_mid;
        middle_row[c] = cur;
        left_hold = old_mid;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    task automatic send_pixel(input pix_t p);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.red_in   <= p[0];
        pix_ch.green_in <= p[1];
        pix_ch.blue_in  <= p[2];
        @(posedge clk);
        while (pix_ch.ready !== 1'b1)
            @(posedge clk);
        predict_edge_map(p);
        pixels_sent++;
    endtask

    // Holds the pixel stream until every predicted result has left the block.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic send_frame(input fill_mode_t mode);
        int unsigned w;
        int unsigned h;
        pix_t        flat;
        w = clamp_size(width_reg, MAX_WIDTH_DEF);
        h = clamp_size(height_reg, MAX_HEIGHT_DEF);
        flat = random_pixel();
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_pixel(fill_pixel(mode, x, y, flat));
    endtask

    task automatic finish_frame();
        while (col_pos != 0 || row_pos != 0)
            send_pixel(random_pixel());
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_edges.size() == 0)
            begin
                $error("result item with no prediction: col %0d row %0d",
                       res_ch.center_col, res_ch.center_row);
                error_count++;
            end
            else
            begin
                head_edge = pending_edges.pop_front();
                check_field("red_out", 16'(head_edge.red), 16'(res_ch.red_out));
                check_field("green_out", 16'(head_edge.green), 16'(res_ch.green_out));
                check_field("blue_out", 16'(head_edge.blue), 16'(res_ch.blue_out));
                check_field("center_col", 16'(head_edge.col), 16'(res_ch.center_col));
                check_field("center_row", 16'(head_edge.row), 16'(res_ch.center_row));
                check_field("frame_last", 16'(head_edge.last), 16'(res_ch.frame_last));
                results_seen++;
                if (head_edge.last)
                    frames_seen++;
            end
        end
        res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_edges.size());
            $display("rgb_gradient_edge_map_unit regression: fail");
            $finish;
        end
    end

    // Diagonal step of full swing: red rises, green falls, so both signs of the
    // largest gradient reach the centers; blue carries odd differences.
    task automatic test_gradient_extremes();
        pix_t p;
        set_geometry(CFG_W'(5), CFG_W'(5));
        for (int y = 0; y < 5; y++)
            for (int x = 0; x < 5; x++)
            begin
                p[0] = (x + y >= 4) ? 8'hFF : 8'h00;
                p[1] = ~p[0];
                p[2] = 8'(x * 37 + y * 91);
                send_pixel(p);
            end
    endtask

    // Sizes below the minimum act as three.
    task automatic test_size_clamp_low();
        set_geometry(CFG_W'(0), CFG_W'(1));
        send_frame(FILL_BINARY);
        set_geometry(CFG_W'(2), CFG_W'(2));
        send_frame(FILL_RANDOM);
        set_geometry(CFG_W'(1), CFG_W'(0));
        send_frame(FILL_RAMP);
    endtask

    // Shrinking the size mid-frame leaves the column, then the row, beyond the
    // new limit; both must wrap without producing results.
    task automatic test_midframe_resize();
        set_geometry(CFG_W'(12), CFG_W'(8));
        repeat (3 * 12 + 9) send_pixel(random_pixel());
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(5));
        while (row_pos != 6)
            send_pixel(random_pixel());
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
        finish_frame();
    endtask

    task automatic test_random_frames();
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        int unsigned      target;
        int unsigned      n;
        fill_mode_t       mode;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            src_idle_pct  = SRC_IDLE[phase];
            sink_idle_pct = SINK_IDLE[phase];
            target = pixels_sent + RANDOM_ITEMS / NUM_PHASES;
            while (pixels_sent < target)
            begin
                w_raw = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 12));
                h_raw = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 6));
                set_geometry(w_raw, h_raw);
                mode = fill_mode_t'($urandom_range(FILL_RANDOM, FILL_RAMP));
                if ($urandom_range(0, 7) == 0)
                begin
                    // Broken frame: cut short, resized, then run out to its end.
                    n = $urandom_range(1, clamp_size(width_reg, MAX_WIDTH_DEF)
                                          * clamp_size(height_reg, MAX_HEIGHT_DEF) - 1);
                    repeat (n) send_pixel(random_pixel());
                    wait_idle();
                    write_reg(REG_FRAME_WIDTH,
                              CFG_W'($urandom_range(MIN_SIZE,
                                                    clamp_size(width_reg, MAX_WIDTH_DEF))));
                    write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 8)));
                    finish_frame();
                end
                else
                    send_frame(mode);
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        pix_ch.valid    = 1'b0;
        pix_ch.red_in   = '0;
        pix_ch.green_in = '0;
        pix_ch.blue_in  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_FRAME_WIDTH;
        cfg_ch.data     = '0;
        res_ch.ready    = 1'b0;
        width_reg       = 11'(WIDTH_RESET);
        height_reg      = 11'(HEIGHT_RESET);
        col_pos         = 0;
        row_pos         = 0;
        left_hold       = '0;
        src_idle_pct    = SRC_IDLE[0];
        sink_idle_pct   = SINK_IDLE[0];
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_gradient_extremes();
        test_size_clamp_low();
        test_midframe_resize();
        test_random_frames();
        wait_idle();

        $display("Checked %0d result items from %0d pixels, %0d frame ends seen.",
                 results_seen, pixels_sent, frames_seen);
        $display("Frames ran from the clamped 3x3 up to 12x8, some cut short and resized.");
        if (error_count == 0)
            $display("rgb_gradient_edge_map_unit regression: pass");
        else
            $display("rgb_gradient_edge_map_unit regression: fail");
        $finish;
    end

endmodule
